@@ rtl/hsvcc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvcc_pkg
// Shared types and constants of the hsv color class counter: fixed-point
// widths of the color conversion, hue and saturation band limits, queue size.
// ----------------------------------------------------------------------------
package hsvcc_pkg;

    // pixel component and result field widths
    localparam int PIX_BITS  = 8;
    localparam int OUT_BITS  = 16;
    localparam int OUT_MAX   = 65535;

    // fixed-point conversion
    localparam int HSV_SHIFT = 12;
    localparam int SAT_NUM   = 255 << HSV_SHIFT;
    localparam int HUE_NUM   = 30 << HSV_SHIFT;
    localparam int SDIV_BITS = 20;             // up to 255 * 4096
    localparam int HDIV_BITS = 17;             // up to 30 * 4096
    localparam int HNUM_BITS = 12;             // signed, -255 .. 1275
    localparam int SPROD_BITS = PIX_BITS + SDIV_BITS;
    localparam int HPROD_BITS = HNUM_BITS + HDIV_BITS + 1;
    localparam int HUE_BITS  = HPROD_BITS - HSV_SHIFT;
    localparam int SAT_BITS  = SPROD_BITS - HSV_SHIFT;
    localparam int HUE_WRAP  = 180;

    // red band, low hues
    localparam int RED_LO_HUE_MAX  = 15;
    localparam int RED_LO_SAT_GT   = 33;
    // red band, high hues
    localparam int RED_HI_HUE_MIN  = 156;
    localparam int RED_HI_HUE_MAX  = 180;
    localparam int RED_HI_SAT_GT   = 42;
    // blue band
    localparam int BLUE_HUE_MIN    = 90;
    localparam int BLUE_HUE_MAX    = 120;
    localparam int BLUE_SAT_GT     = 24;
    // yellow band
    localparam int YEL_HUE_MIN     = 16;
    localparam int YEL_HUE_MAX     = 36;
    localparam int YEL_SAT_GT      = 77;
    // saturation must stay below this in every band
    localparam int SAT_LIMIT       = 255;

    // class queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // tally slots
    localparam int TALLY_NUM   = 4;
    localparam int IDX_RED     = 0;
    localparam int IDX_BLUE    = 1;
    localparam int IDX_YELLOW  = 2;
    localparam int IDX_TOTAL   = 3;

    // one classified pixel
    typedef struct packed {
        logic last;
        logic yellow;
        logic blue;
        logic red;
    } cls_item_t;

endpackage

@@ rtl/hsvcc_front.sv @@
// ----------------------------------------------------------------------------
// hsvcc_front
// Three-stage pixel pipeline: max/min and hue numerator, reciprocal table
// lookup, multiply; the stage-three products are turned into hue and
// saturation and classified into color bands on the way into the queue.
// ----------------------------------------------------------------------------
module hsvcc_front
    import hsvcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  logic [PIX_BITS-1:0] pixel_blue,
    input  logic [PIX_BITS-1:0] pixel_green,
    input  logic [PIX_BITS-1:0] pixel_red,
    input  logic                region_end,
    output logic                cls_valid,
    input  logic                cls_ready,
    output cls_item_t           cls_item
);

    // reciprocal tables, worked out at elaboration, rounded half to even
    wire [SDIV_BITS-1:0] sdiv_tab [256];
    wire [HDIV_BITS-1:0] hdiv_tab [256];

    for (genvar gi = 0; gi < 256; gi++) begin : g_tab
        localparam int D   = (gi == 0) ? 1 : gi;
        localparam int SQ  = SAT_NUM / D;
        localparam int SR  = SAT_NUM % D;
        localparam int SQR = ((2 * SR > D) || ((2 * SR == D) && (SQ % 2 == 1))) ? SQ + 1 : SQ;
        localparam int HQ  = HUE_NUM / D;
        localparam int HR  = HUE_NUM % D;
        localparam int HQR = ((2 * HR > D) || ((2 * HR == D) && (HQ % 2 == 1))) ? HQ + 1 : HQ;
        assign sdiv_tab[gi] = (gi == 0) ? '0 : SDIV_BITS'(SQR);
        assign hdiv_tab[gi] = (gi == 0) ? '0 : HDIV_BITS'(HQR);
    end

    logic advance;

    // stage 1 registers
    logic                        s1_valid_reg;
    logic [PIX_BITS-1:0]         s1_v_reg, s1_v_next;
    logic [PIX_BITS-1:0]         s1_diff_reg, s1_diff_next;
    logic signed [HNUM_BITS-1:0] s1_hnum_reg, s1_hnum_next;
    logic                        s1_last_reg;

    // stage 2 registers
    logic                        s2_valid_reg;
    logic [SDIV_BITS-1:0]        s2_sdiv_reg;
    logic [HDIV_BITS-1:0]        s2_hdiv_reg;
    logic [PIX_BITS-1:0]         s2_diff_reg;
    logic signed [HNUM_BITS-1:0] s2_hnum_reg;
    logic                        s2_last_reg;

    // stage 3 registers
    logic                         s3_valid_reg;
    logic [SPROD_BITS-1:0]        s3_sprod_reg, s3_sprod_next;
    logic signed [HPROD_BITS-1:0] s3_hprod_reg, s3_hprod_next;
    logic                         s3_last_reg;

    // whole pipeline moves together, held only by a full queue
    assign advance   = !s3_valid_reg || cls_ready;
    assign pix_ready = advance;

    // value, minimum, spread and hue numerator
    always_comb
    begin
        logic [PIX_BITS-1:0]         mx;
        logic [PIX_BITS-1:0]         mn;
        logic signed [HNUM_BITS-1:0] b_s;
        logic signed [HNUM_BITS-1:0] g_s;
        logic signed [HNUM_BITS-1:0] r_s;
        logic signed [HNUM_BITS-1:0] d_s;
        mx = pixel_red;
        if (pixel_green > mx)
            mx = pixel_green;
        if (pixel_blue > mx)
            mx = pixel_blue;
        mn = pixel_red;
        if (pixel_green < mn)
            mn = pixel_green;
        if (pixel_blue < mn)
            mn = pixel_blue;
        b_s = HNUM_BITS'(pixel_blue);
        g_s = HNUM_BITS'(pixel_green);
        r_s = HNUM_BITS'(pixel_red);
        d_s = HNUM_BITS'(mx - mn);
        s1_v_next    = mx;
        s1_diff_next = mx - mn;
        if (mx == pixel_red)
            s1_hnum_next = g_s - b_s;
        else if (mx == pixel_green)
            s1_hnum_next = b_s - r_s + (d_s <<< 1);
        else
            s1_hnum_next = r_s - g_s + (d_s <<< 2);
    end

    // products of stage 2
    always_comb
    begin
        s3_sprod_next = SPROD_BITS'(s2_diff_reg) * SPROD_BITS'(s2_sdiv_reg);
        s3_hprod_next = HPROD_BITS'(s2_hnum_reg) *
                        HPROD_BITS'(signed'({1'b0, s2_hdiv_reg}));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pix_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_v_reg     <= s1_v_next;
            s1_diff_reg  <= s1_diff_next;
            s1_hnum_reg  <= s1_hnum_next;
            s1_last_reg  <= region_end;
            s2_sdiv_reg  <= sdiv_tab[s1_v_reg];
            s2_hdiv_reg  <= hdiv_tab[s1_diff_reg];
            s2_diff_reg  <= s1_diff_reg;
            s2_hnum_reg  <= s1_hnum_reg;
            s2_last_reg  <= s1_last_reg;
            s3_sprod_reg <= s3_sprod_next;
            s3_hprod_reg <= s3_hprod_next;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // round, wrap hue and test the bands
    always_comb
    begin
        logic [SPROD_BITS-1:0]        ssum;
        logic signed [HPROD_BITS-1:0] hsum;
        logic [SAT_BITS-1:0]          sat;
        logic signed [HUE_BITS-1:0]   hue_raw;
        logic signed [HUE_BITS-1:0]   hue;
        logic                         sat_top;
        ssum    = s3_sprod_reg + SPROD_BITS'(1 << (HSV_SHIFT - 1));
        hsum    = s3_hprod_reg + HPROD_BITS'(1 << (HSV_SHIFT - 1));
        sat     = ssum[SPROD_BITS-1:HSV_SHIFT];
        hue_raw = hsum[HPROD_BITS-1:HSV_SHIFT];
        hue     = hue_raw[HUE_BITS-1] ? hue_raw + HUE_BITS'(HUE_WRAP) : hue_raw;
        sat_top = sat < SAT_BITS'(SAT_LIMIT);
        cls_item.last   = s3_last_reg;
        cls_item.red    = sat_top &&
                          ((hue <= RED_LO_HUE_MAX && sat > SAT_BITS'(RED_LO_SAT_GT)) ||
                           (hue >= RED_HI_HUE_MIN && hue <= RED_HI_HUE_MAX &&
                            sat > SAT_BITS'(RED_HI_SAT_GT)));
        cls_item.blue   = sat_top && hue >= BLUE_HUE_MIN && hue <= BLUE_HUE_MAX &&
                          sat > SAT_BITS'(BLUE_SAT_GT);
        cls_item.yellow = sat_top && hue >= YEL_HUE_MIN && hue <= YEL_HUE_MAX &&
                          sat > SAT_BITS'(YEL_SAT_GT);
    end

    assign cls_valid = s3_valid_reg;

endmodule

@@ rtl/hsvcc_queue.sv @@
// ----------------------------------------------------------------------------
// hsvcc_queue
// Short first-in first-out queue of classified pixels between the front
// pipeline and the tally back end.
// ----------------------------------------------------------------------------
module hsvcc_queue
    import hsvcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  cls_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cls_item_t pop_item
);

    cls_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // fill level never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

endmodule

@@ rtl/hsvcc_tally.sv @@
// ----------------------------------------------------------------------------
// hsvcc_tally
// Saturating class counters fed from the queue; the last pixel of a region
// loads the clamped counts into the result register and clears the counters.
// ----------------------------------------------------------------------------
module hsvcc_tally
    import hsvcc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  cls_item_t           item,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [OUT_BITS-1:0] red_hits,
    output logic [OUT_BITS-1:0] blue_hits,
    output logic [OUT_BITS-1:0] yellow_hits,
    output logic [OUT_BITS-1:0] pixel_total
);

    logic [COUNT_BITS-1:0] tally_reg [TALLY_NUM];
    logic [COUNT_BITS-1:0] tally_next [TALLY_NUM];
    logic [COUNT_BITS-1:0] bumped [TALLY_NUM];
    logic [OUT_BITS-1:0]   clamped [TALLY_NUM];
    logic [OUT_BITS-1:0]   res_reg [TALLY_NUM];
    logic [TALLY_NUM-1:0]  hit;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;
    logic                  pop;
    logic                  close;

    assign hit[IDX_RED]    = item.red;
    assign hit[IDX_BLUE]   = item.blue;
    assign hit[IDX_YELLOW] = item.yellow;
    assign hit[IDX_TOTAL]  = 1'b1;

    // a closing pixel waits until the result register is free
    assign out_free   = !out_valid_reg || res_ready;
    assign pop        = item_valid && (!item.last || out_free);
    assign close      = pop && item.last;
    assign item_ready = !item.last || out_free;

    // saturating increments and clamp to the result width
    for (genvar gi = 0; gi < TALLY_NUM; gi++) begin : g_cnt
        assign bumped[gi] = (hit[gi] && tally_reg[gi] != '1) ?
                            tally_reg[gi] + COUNT_BITS'(1) : tally_reg[gi];
        if (COUNT_BITS > OUT_BITS) begin : g_clamp
            assign clamped[gi] = (bumped[gi] > COUNT_BITS'(OUT_MAX)) ?
                                 '1 : bumped[gi][OUT_BITS-1:0];
        end
        else begin : g_wide
            assign clamped[gi] = OUT_BITS'(bumped[gi]);
        end
    end

    // next counter and result valid state
    always_comb
    begin
        for (int i = 0; i < TALLY_NUM; i++)
        begin
            if (close)
                tally_next[i] = '0;
            else if (pop)
                tally_next[i] = bumped[i];
            else
                tally_next[i] = tally_reg[i];
        end
        if (close)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TALLY_NUM; i++)
                tally_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (close)
            res_reg <= clamped;
    end

    assign res_valid   = out_valid_reg;
    assign red_hits    = res_reg[IDX_RED];
    assign blue_hits   = res_reg[IDX_BLUE];
    assign yellow_hits = res_reg[IDX_YELLOW];
    assign pixel_total = res_reg[IDX_TOTAL];

    // a closing pixel never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        close |-> (!out_valid_reg || res_ready))
        else $error("result overwritten before transaction");

    // counters are empty after a region closes
    a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        close |=> (tally_reg[IDX_TOTAL] == '0 && tally_reg[IDX_RED] == '0))
        else $error("tallies not cleared after region end");

    // no class count runs ahead of the pixel total
    a_class_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg[IDX_RED] <= tally_reg[IDX_TOTAL] &&
        tally_reg[IDX_BLUE] <= tally_reg[IDX_TOTAL] &&
        tally_reg[IDX_YELLOW] <= tally_reg[IDX_TOTAL])
        else $error("class count above pixel total");

    // a result shows up in the cycle after a closing pixel
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        close |=> res_valid)
        else $error("missing result after region end");

endmodule

@@ rtl/hsv_color_class_counter_unit.sv @@
// ----------------------------------------------------------------------------
// hsv_color_class_counter_unit
// Converts each BGR pixel of a region to HSV, sorts it into red, blue or
// yellow bands and counts; the last pixel of the region emits the counts.
//
//  channel  dir  tdata fields (low bit up)                      tlast
//  s_axis   in   pixel_blue, pixel_green, pixel_red (24 bits)   region_end
//  m_axis   out  red_hits, blue_hits, yellow_hits, pixel_total  -
//
//  One pixel per cycle while the class queue has room. m_tvalid rises
//  once the closing pixel is taken and has passed two more front stages,
//  the class queue register and the tally result register.
//  rst_n clears valid bits, queue pointers, counters and the result flag.
//  A held result stalls only the closing pixel of the next region; other
//  pixels keep flowing until the four-entry class queue fills.
// ----------------------------------------------------------------------------
module hsv_color_class_counter_unit
    import hsvcc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_blue, pixel_green, pixel_red
    input  logic        s_tlast,   // region_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // red_hits, blue_hits, yellow_hits, pixel_total
);

    logic      f_valid;
    logic      f_ready;
    cls_item_t f_item;
    logic      q_valid;
    logic      q_ready;
    cls_item_t q_item;

    // color conversion and classification
    hsvcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (s_tvalid),
        .pix_ready   (s_tready),
        .pixel_blue  (s_tdata[7:0]),
        .pixel_green (s_tdata[15:8]),
        .pixel_red   (s_tdata[23:16]),
        .region_end  (s_tlast),
        .cls_valid   (f_valid),
        .cls_ready   (f_ready),
        .cls_item    (f_item)
    );

    // class queue
    hsvcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // counters and result register
    hsvcc_tally #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .red_hits    (m_tdata[15:0]),
        .blue_hits   (m_tdata[31:16]),
        .yellow_hits (m_tdata[47:32]),
        .pixel_total (m_tdata[63:48])
    );

endmodule
